@@ hdl/stf_pkg.sv @@
// Shared types, constants and frame helpers for the stackmat timer frame engine.
package stf_pkg;

  localparam int FRAME_MAX   = 10;
  localparam int IDX_W       = $clog2(FRAME_MAX);
  localparam int SHORT_LEN   = 6;
  localparam int TIME_LEN    = 10;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] CRC_INIT = 16'hffff;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // reciprocals: t/1000 = (t*M) >> 38, t/60000 = (t*M) >> 46, exact for 32-bit t
  localparam logic [31:0] RECIP_1000  = 32'h10624dd3;
  localparam logic [31:0] RECIP_60000 = 32'h45e7b273;

  localparam logic [15:0] READY_DELAY_RESET = 16'd1200;

  // action codes
  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_HANDS_ON  = 3'd1;
  localparam logic [2:0] ACT_READY     = 3'd2;
  localparam logic [2:0] ACT_HANDS_OFF = 3'd3;
  localparam logic [2:0] ACT_START     = 3'd4;
  localparam logic [2:0] ACT_STOP      = 3'd5;
  localparam logic [2:0] ACT_RESET     = 3'd6;

  // register index
  localparam logic REG_READY_DELAY = 1'b0;

  typedef enum logic [2:0] {
    FRM_NONE,
    FRM_HANDS_ON,
    FRM_READY,
    FRM_HANDS_OFF,
    FRM_RUNNING,
    FRM_STOP,
    FRM_RESET
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t  kind;
    logic [31:0]  tval;
    logic         armed;
    logic         running;
    logic [31:0]  shown;
  } frame_desc_t;

  typedef enum logic [1:0] {
    CALC_S0,
    CALC_S1,
    CALC_S2,
    CALC_DONE
  } calc_state_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] x;
    x = c ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

  function automatic logic [7:0] short_byte(input frame_kind_t kind,
                                            input logic [IDX_W-1:0] idx);
    logic [7:0] code, c_lo, c_hi, r;
    code = 8'h00;
    c_lo = 8'h00;
    c_hi = 8'h00;
    case (kind)
      FRM_HANDS_ON: begin
        code = 8'h06; c_lo = 8'hf8; c_hi = 8'h4e;
      end
      FRM_READY: begin
        code = 8'h01; c_lo = 8'h1f; c_hi = 8'h3e;
      end
      FRM_HANDS_OFF: begin
        code = 8'h02; c_lo = 8'h7c; c_hi = 8'h0e;
      end
      FRM_RUNNING: begin
        code = 8'h03; c_lo = 8'h5d; c_hi = 8'h1e;
      end
      default: begin
        code = 8'h00; c_lo = 8'h00; c_hi = 8'h00;
      end
    endcase
    case (idx)
      IDX_W'(0): r = 8'hfe;
      IDX_W'(1): r = 8'h04;
      IDX_W'(2): r = 8'h01;
      IDX_W'(3): r = code;
      IDX_W'(4): r = c_lo;
      IDX_W'(5): r = c_hi;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/stf_front.sv @@
// Front end: holds timer flags and counter, classifies each event into a frame descriptor.
module stf_front import stf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [2:0]  action,
  input  logic        link_connected,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic [15:0] ready_delay,
  output frame_desc_t desc
);

  logic        run_state, hands_state, armed_state;
  logic [31:0] elapsed_count, last_time;
  logic        run_next, hands_next, armed_next;
  logic [31:0] elapsed_next, last_time_next;
  frame_kind_t kind;

  always_comb begin
    run_next       = run_state;
    hands_next     = hands_state;
    armed_next     = armed_state;
    elapsed_next   = elapsed_count;
    last_time_next = last_time;
    kind           = FRM_NONE;
    case (action)
      ACT_TICK: begin
        if (elapsed_count != 32'hffffffff) elapsed_next = elapsed_count + 32'd1;
      end
      ACT_HANDS_ON: begin
        if (!run_state && !hands_state) begin
          elapsed_next = '0;
          hands_next   = 1'b1;
          kind         = FRM_HANDS_ON;
        end
      end
      ACT_READY: begin
        if (!armed_state && hands_state && (elapsed_count >= {16'd0, ready_delay})) begin
          armed_next = 1'b1;
          kind       = FRM_READY;
        end
      end
      ACT_HANDS_OFF: begin
        if (!run_state && hands_state) begin
          elapsed_next = '0;
          armed_next   = 1'b0;
          hands_next   = 1'b0;
          kind         = FRM_HANDS_OFF;
        end
      end
      ACT_START: begin
        if (!(run_state && !armed_state)) begin
          run_next     = 1'b1;
          armed_next   = 1'b0;
          hands_next   = 1'b0;
          elapsed_next = '0;
          kind         = FRM_RUNNING;
        end
      end
      ACT_STOP: begin
        if (run_state) begin
          run_next       = 1'b0;
          last_time_next = elapsed_count;
          kind           = FRM_STOP;
        end
      end
      ACT_RESET: begin
        run_next = 1'b0;
        kind     = FRM_RESET;
      end
      default: begin
        kind = FRM_NONE;
      end
    endcase
    // drop the frame while no partner listens
    if (!link_connected) kind = FRM_NONE;

    desc.kind    = kind;
    desc.tval    = last_time_next;
    desc.armed   = armed_next;
    desc.running = run_next;
    desc.shown   = run_next ? elapsed_next : last_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state     <= 1'b0;
      hands_state   <= 1'b0;
      armed_state   <= 1'b0;
      elapsed_count <= '0;
      last_time     <= '0;
    end else if (in_valid) begin
      run_state     <= run_next;
      hands_state   <= hands_next;
      armed_state   <= armed_next;
      elapsed_count <= elapsed_next;
      last_time     <= last_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_delay <= READY_DELAY_RESET;
    end else if (cfg_we) begin
      ready_delay <= cfg_wdata;
    end
  end

endmodule

@@ hdl/stf_queue.sv @@
// Short descriptor queue between front and back, head readable without a pop cycle.
module stf_queue import stf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_desc_t push_desc,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output frame_desc_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_desc_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/stf_back.sv @@
// Back end: splits the time, runs the CRC and serializes frame bytes into the output register.
module stf_back import stf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  frame_desc_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last,
  output logic        out_armed,
  output logic        out_running,
  output logic [31:0] out_shown
);

  calc_state_t       calc, calc_next;
  logic [63:0]       prod_sec, prod_min;
  logic [22:0]       total_sec;
  logic [16:0]       minutes;
  logic [9:0]        ms_part;
  logic [5:0]        sec_part;
  logic [15:0]       crc;
  logic [IDX_W-1:0]  idx;
  logic              is_time, load, last_now;
  logic [IDX_W-1:0]  len;
  logic [7:0]        byte_now;
  logic [31:0]       ms_wide;
  logic [22:0]       sec_wide;

  assign is_time = (head.kind == FRM_STOP) || (head.kind == FRM_RESET);

  always_comb begin
    case (head.kind) inside
      FRM_NONE:            len = IDX_W'(1);
      FRM_STOP, FRM_RESET: len = IDX_W'(TIME_LEN);
      default:             len = IDX_W'(SHORT_LEN);
    endcase
  end

  assign last_now = (idx == len - IDX_W'(1));
  assign load     = head_valid && (!out_valid || out_ready) && (!is_time || calc == CALC_DONE);
  assign pop      = load && last_now;

  // time split pipeline, runs on the stable head
  assign ms_wide  = head.tval - (32'(total_sec) * 32'd1000);
  assign sec_wide = total_sec - (23'(minutes) * 23'd60);

  always_ff @(posedge clk) begin
    prod_sec  <= head.tval * RECIP_1000;
    prod_min  <= head.tval * RECIP_60000;
    total_sec <= prod_sec[60:38];
    minutes   <= prod_min[62:46];
    ms_part   <= ms_wide[9:0];
    sec_part  <= sec_wide[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) calc <= CALC_S0;
    else     calc <= calc_next;
  end

  always_comb begin
    calc_next = calc;
    if (pop) begin
      calc_next = CALC_S0;
    end else if (head_valid) begin
      unique case (calc)
        CALC_S0:   calc_next = CALC_S1;
        CALC_S1:   calc_next = CALC_S2;
        CALC_S2:   calc_next = CALC_DONE;
        CALC_DONE: calc_next = CALC_DONE;
        default:   calc_next = CALC_S0;
      endcase
    end
  end

  always_comb begin
    if (head.kind == FRM_NONE) begin
      byte_now = 8'h00;
    end else if (is_time) begin
      case (idx)
        IDX_W'(0): byte_now = 8'hfe;
        IDX_W'(1): byte_now = 8'h08;
        IDX_W'(2): byte_now = 8'h01;
        IDX_W'(3): byte_now = (head.kind == FRM_STOP) ? 8'h04 : 8'h05;
        IDX_W'(4): byte_now = minutes[7:0];
        IDX_W'(5): byte_now = {2'b00, sec_part};
        IDX_W'(6): byte_now = ms_part[7:0];
        IDX_W'(7): byte_now = {6'd0, ms_part[9:8]};
        IDX_W'(8): byte_now = crc[7:0];
        IDX_W'(9): byte_now = crc[15:8];
        default:   byte_now = 8'h00;
      endcase
    end else begin
      byte_now = short_byte(head.kind, idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      crc <= CRC_INIT;
    end else if (load) begin
      if (last_now) begin
        idx <= '0;
        crc <= CRC_INIT;
      end else begin
        idx <= idx + IDX_W'(1);
        if (idx >= IDX_W'(2) && idx <= IDX_W'(7)) crc <= crc_byte(crc, byte_now);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= byte_now;
      out_byte_valid <= (head.kind != FRM_NONE);
      out_last       <= last_now;
      out_armed      <= head.armed;
      out_running    <= head.running;
      out_shown      <= head.shown;
    end
  end

  a_status_single : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_byte_valid |-> out_last)
    else $error("status-only word not marked last");

  a_crc_fresh : assert property (@(posedge clk) disable iff (rst)
    load && (idx == '0) |-> (crc == CRC_INIT))
    else $error("crc not reinitialized at frame start");

  a_time_ready : assert property (@(posedge clk) disable iff (rst)
    load && is_time |-> (calc == CALC_DONE))
    else $error("time frame sent before split finished");

  a_pop_restarts : assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == '0) && (calc == CALC_S0))
    else $error("back end did not restart after frame");

endmodule

@@ hdl/stackmat_timer_frame_engine.sv @@
// Top level of the stackmat timer frame engine: stream ports, register port, front/queue/back.
//
// Usage:
//   Input stream (s_*): one word per event; s_tdata[2:0] action (0 tick, 1 hands on,
//   2 ready check, 3 hands off, 4 start, 5 stop, 6 reset), s_tdata[3] link_connected.
//   Output stream (m_*): one word per frame byte, or a single status-only word when
//   no frame goes out; m_tlast marks the final word of each event.
//   Register port: ready_delay_ms at byte address 0; write it only while idle.
// Timing: fixed frames and status words pass through the queue entry and the
//   output register; time frames first wait in states S0, S1 and S2 of the
//   time split by reciprocal multiply before the first byte.
// Throughput: one output word per cycle while m_tready is high and no time split
//   is pending; an event gives 1, 6 or 10 words; the front end takes one event per
//   cycle while the four-entry descriptor queue has room, so ticks stream in back-to-back.
// Reset: flags, counter and stored time clear, ready_delay_ms returns to 1200,
//   queue and output empty; no clearing pass is needed.
// Stall: when m_tready is low the output word holds; the queue fills and then
//   s_tready drops until the back end drains.
module stackmat_timer_frame_engine import stf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] action, [3] link_connected, [7:4] zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] frame_byte, [8] ready_out, [9] running_out,
                                 // [41:10] shown_ms, [47:42] zero
  output logic [0:0]  m_tuser,   // [0] byte_valid
  output logic        m_tlast,   // last word of this event
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  frame_desc_t desc, head;
  logic        in_take, q_full, head_valid, pop, cfg_we;
  logic [15:0] ready_delay;
  logic [7:0]  out_byte;
  logic        out_byte_valid, out_armed, out_running;
  logic [31:0] out_shown;

  // register port: always ready, decode on the word index
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_READY_DELAY);
  assign prdata = (paddr[2] == REG_READY_DELAY) ? {16'd0, ready_delay} : 32'd0;

  // take an event whenever the queue has room
  assign s_tready = !q_full;
  assign in_take  = s_tvalid && s_tready;

  stf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_take),
    .action         (s_tdata[2:0]),
    .link_connected (s_tdata[3]),
    .cfg_we         (cfg_we),
    .cfg_wdata      (pwdata[15:0]),
    .ready_delay    (ready_delay),
    .desc           (desc)
  );

  stf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_take),
    .push_desc  (desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  stf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (m_tlast),
    .out_armed      (out_armed),
    .out_running    (out_running),
    .out_shown      (out_shown)
  );

  // pack the output word, frame byte lowest
  assign m_tdata    = {6'd0, out_shown, out_running, out_armed, out_byte};
  assign m_tuser[0] = out_byte_valid;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the stackmat timer frame engine: directed and random events.
`timescale 1ns / 1ps

module testbench import stf_pkg::*; ();

  // Action code that the block must treat as a no-op.
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  // Frame layout bytes and frame codes.
  localparam logic [7:0] SYNC_BYTE      = 8'hfe;
  localparam logic [7:0] LEN_SHORT      = 8'h04;
  localparam logic [7:0] LEN_TIME       = 8'h08;
  localparam logic [7:0] DEVICE_BYTE    = 8'h01;
  localparam logic [7:0] CODE_READY     = 8'h01;
  localparam logic [7:0] CODE_HANDS_OFF = 8'h02;
  localparam logic [7:0] CODE_RUNNING   = 8'h03;
  localparam logic [7:0] CODE_STOPPED   = 8'h04;
  localparam logic [7:0] CODE_RESET     = 8'h05;
  localparam logic [7:0] CODE_HANDS_ON  = 8'h06;
  localparam int SHORT_WORDS = 6;
  localparam int TIME_WORDS  = 10;

  localparam logic [15:0] DELAY_MAX = 16'hffff;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;   // [2:0] action, [3] link_connected, [7:4] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;            // [7:0] frame_byte, [8] ready_out, [9] running_out,
                                   // [41:10] shown_ms, [47:42] zero
  logic [0:0]  m_tuser;            // [0] byte_valid
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = 3'd0;
  logic [31:0] pwdata   = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  stackmat_timer_frame_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // One output word as the block should present it.
  typedef struct {
    logic [7:0]  fbyte;
    logic        has_byte;
    logic        is_last;
    logic        ready;
    logic        running;
    logic [31:0] shown;
  } frame_word_t;

  // One row of the directed part: an event or a register write.
  typedef struct {
    logic        is_cfg;
    logic [2:0]  act;
    logic        lnk;
    logic [15:0] cfg_val;
    int          want_words;   // 0 when the row carries no typed-in answer
    logic [7:0]  want_code;
  } plan_row_t;

  frame_word_t pending_words[$];
  plan_row_t   plan[$];

  // Timer state as the block should hold it.
  logic        tmr_running = 1'b0;
  logic        tmr_hands   = 1'b0;
  logic        tmr_armed   = 1'b0;
  logic [31:0] ms_count    = 32'd0;
  logic [31:0] stopped_ms  = 32'd0;
  logic [15:0] delay_ms    = READY_DELAY_RESET;
  logic [7:0]  frame_img [0:FRAME_MAX-1];

  int          predicted_words;
  logic [7:0]  predicted_code;
  int          n_events      = 0;
  int          mismatches    = 0;
  int          send_idle_pct = 29;
  int          recv_idle_pct = 64;
  int          cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver back-pressure: stall at random at the current rate.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Pop the oldest expected word on every accepted output word and compare.
  always @(posedge clk) begin
    frame_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word tdata %h tuser %b tlast %b",
                                m_tdata, m_tuser, m_tlast));
      end else begin
        want = pending_words.pop_front();
        compare_field("frame_byte", 32'(m_tdata[7:0]), 32'(want.fbyte));
        compare_field("byte_valid", 32'(m_tuser[0]), 32'(want.has_byte));
        compare_field("last", 32'(m_tlast), 32'(want.is_last));
        compare_field("ready_out", 32'(m_tdata[8]), 32'(want.ready));
        compare_field("running_out", 32'(m_tdata[9]), 32'(want.running));
        compare_field("shown_ms", m_tdata[41:10], want.shown);
      end
    end
  end

  // CRC-16, init all ones, MSB first, over bytes 2..7 (device byte, code and time fields).
  function automatic logic [15:0] time_frame_crc();
    logic [15:0] acc;
    acc = CRC_INIT;
    for (int i = 2; i < 8; i++) begin
      acc = acc ^ {frame_img[i], 8'h00};
      for (int b = 0; b < 8; b++) begin
        acc = acc[15] ? ({acc[14:0], 1'b0} ^ CRC_POLY) : {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

  task automatic build_short_frame(input logic [7:0] code, input logic [7:0] chk_lo,
                                   input logic [7:0] chk_hi);
    frame_img[0] = SYNC_BYTE;
    frame_img[1] = LEN_SHORT;
    frame_img[2] = DEVICE_BYTE;
    frame_img[3] = code;
    frame_img[4] = chk_lo;
    frame_img[5] = chk_hi;
  endtask

  // Minutes keep only their low 8 bits; the ms remainder goes low byte first.
  task automatic build_time_frame(input logic [7:0] code, input logic [31:0] t);
    logic [31:0] mins, secs, msr;
    logic [15:0] crc;
    mins = t / 60000;
    secs = (t / 1000) % 60;
    msr  = t % 1000;
    frame_img[0] = SYNC_BYTE;
    frame_img[1] = LEN_TIME;
    frame_img[2] = DEVICE_BYTE;
    frame_img[3] = code;
    frame_img[4] = mins[7:0];
    frame_img[5] = secs[7:0];
    frame_img[6] = msr[7:0];
    frame_img[7] = msr[15:8];
    crc = time_frame_crc();
    frame_img[8] = crc[7:0];
    frame_img[9] = crc[15:8];
  endtask

  // Advance the timer state for one event and queue the words it should produce.
  task automatic predict_timer_frame(input logic [2:0] act, input logic lnk);
    int          len;
    frame_word_t w;
    len = 0;
    case (act)
      ACT_TICK: begin
        if (ms_count != 32'hffffffff) ms_count = ms_count + 1;
      end
      ACT_HANDS_ON: begin
        if (!tmr_running && !tmr_hands) begin
          ms_count  = 32'd0;
          tmr_hands = 1'b1;
          build_short_frame(CODE_HANDS_ON, 8'hf8, 8'h4e);
          len = SHORT_WORDS;
        end
      end
      ACT_READY: begin
        if (!tmr_armed && tmr_hands && ms_count >= {16'h0000, delay_ms}) begin
          tmr_armed = 1'b1;
          build_short_frame(CODE_READY, 8'h1f, 8'h3e);
          len = SHORT_WORDS;
        end
      end
      ACT_HANDS_OFF: begin
        if (!tmr_running && tmr_hands) begin
          ms_count  = 32'd0;
          tmr_armed = 1'b0;
          tmr_hands = 1'b0;
          build_short_frame(CODE_HANDS_OFF, 8'h7c, 8'h0e);
          len = SHORT_WORDS;
        end
      end
      ACT_START: begin
        // a running timer only restarts from the ready state
        if (!(tmr_running && !tmr_armed)) begin
          tmr_running = 1'b1;
          tmr_armed   = 1'b0;
          tmr_hands   = 1'b0;
          ms_count    = 32'd0;
          build_short_frame(CODE_RUNNING, 8'h5d, 8'h1e);
          len = SHORT_WORDS;
        end
      end
      ACT_STOP: begin
        if (tmr_running) begin
          tmr_running = 1'b0;
          stopped_ms  = ms_count;
          build_time_frame(CODE_STOPPED, stopped_ms);
          len = TIME_WORDS;
        end
      end
      ACT_RESET: begin
        tmr_running = 1'b0;
        build_time_frame(CODE_RESET, stopped_ms);
        len = TIME_WORDS;
      end
      default: begin
      end
    endcase

    // no partner: a single status word instead of the frame
    if (!lnk) len = 0;
    predicted_words = (len != 0) ? len : 1;
    predicted_code  = (len != 0) ? frame_img[3] : 8'h00;
    for (int k = 0; k < predicted_words; k++) begin
      w.fbyte    = (len != 0) ? frame_img[k] : 8'h00;
      w.has_byte = (len != 0);
      w.is_last  = (k == predicted_words - 1);
      w.ready    = tmr_armed;
      w.running  = tmr_running;
      w.shown    = tmr_running ? ms_count : stopped_ms;
      pending_words.push_back(w);
    end
  endtask

  // Drive one event word; hold tvalid high across back-to-back words.
  task automatic send_event(input logic [2:0] act, input logic lnk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, lnk, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_timer_frame(act, lnk);
    n_events++;
  endtask

  // Send a run of millisecond ticks, each with a random link flag.
  task automatic run_ticks(input int n);
    repeat (n) send_event(ACT_TICK, 1'($urandom_range(1)));
  endtask

  // Write ready_delay_ms once the block has drained; upper data bits are junk.
  task automatic set_ready_delay(input logic [15:0] val);
    logic [31:0] junk;
    junk = $urandom;
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_READY_DELAY, 2'b00};
    pwdata  <= {junk[31:16], val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    delay_ms = val;
  endtask

  // One hands-on / ready / start / stop round, sometimes broken off early or followed by a reset.
  task automatic timer_round();
    logic lnk;
    int   cut, n;
    lnk = ($urandom_range(9) != 0);
    cut = $urandom_range(7);
    send_event(ACT_HANDS_ON, lnk);
    if (cut == 0) return;
    // rest the hands for about the ready delay, unless it is out of reach
    if (delay_ms <= 60) n = $urandom_range(delay_ms + 4, 0);
    else if (delay_ms == DELAY_MAX) n = $urandom_range(20, 0);
    else n = $urandom_range(delay_ms + 4, delay_ms - 4);
    run_ticks(n);
    send_event(ACT_READY, lnk);
    if (cut == 1) begin
      send_event(ACT_HANDS_OFF, lnk);
      return;
    end
    if (cut == 2) send_event(ACT_READY, lnk);
    send_event(ACT_START, lnk);
    // short solves keep the item count down
    n = $urandom_range(20, 0);
    run_ticks(n);
    if (cut == 3) begin
      send_event(ACT_RESET, lnk);
      return;
    end
    send_event(ACT_STOP, lnk);
    if ($urandom_range(1)) send_event(ACT_RESET, lnk);
  endtask

  task automatic random_phase(input int budget, input logic [15:0] delay_val);
    int stop_at;
    set_ready_delay(delay_val);
    stop_at = n_events + budget;
    while (n_events < stop_at) begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(4, 1))
          send_event(3'($urandom_range(7)), 1'($urandom_range(1)));
      end else begin
        timer_round();
      end
    end
  endtask

  task automatic plan_event(input logic [2:0] act, input logic lnk, input int words,
                            input logic [7:0] code);
    plan_row_t r;
    r.is_cfg     = 1'b0;
    r.act        = act;
    r.lnk        = lnk;
    r.cfg_val    = 16'h0000;
    r.want_words = words;
    r.want_code  = code;
    plan.push_back(r);
  endtask

  task automatic plan_config(input logic [15:0] val);
    plan_row_t r;
    r.is_cfg     = 1'b1;
    r.act        = ACT_TICK;
    r.lnk        = 1'b0;
    r.cfg_val    = val;
    r.want_words = 0;
    r.want_code  = 8'h00;
    plan.push_back(r);
  endtask

  initial begin
    // Directed part, reset delay of 1200 first.
    plan_event(ACT_RESET,     1'b1, TIME_WORDS,  CODE_RESET);    // zero time frame
    plan_event(ACT_STOP,      1'b1, 1,           8'h00);         // not running
    plan_event(ACT_UNUSED,    1'b1, 1,           8'h00);
    plan_event(ACT_HANDS_ON,  1'b1, SHORT_WORDS, CODE_HANDS_ON);
    plan_event(ACT_READY,     1'b1, 1,           8'h00);         // rested too short
    plan_event(ACT_TICK,      1'b1, 1,           8'h00);
    plan_event(ACT_HANDS_OFF, 1'b1, SHORT_WORDS, CODE_HANDS_OFF);
    plan_config(16'h0000);
    plan_event(ACT_HANDS_ON,  1'b1, SHORT_WORDS, CODE_HANDS_ON);
    plan_event(ACT_READY,     1'b1, SHORT_WORDS, CODE_READY);
    plan_event(ACT_READY,     1'b1, 1,           8'h00);         // already ready
    plan_event(ACT_START,     1'b1, SHORT_WORDS, CODE_RUNNING);
    plan_event(ACT_START,     1'b1, 1,           8'h00);         // running, not ready
    plan_event(ACT_TICK,      1'b1, 1,           8'h00);
    plan_event(ACT_TICK,      1'b0, 1,           8'h00);
    plan_event(ACT_TICK,      1'b1, 1,           8'h00);
    plan_event(ACT_STOP,      1'b1, TIME_WORDS,  CODE_STOPPED);
    plan_event(ACT_HANDS_ON,  1'b0, 1,           8'h00);         // no partner
    plan_event(ACT_READY,     1'b1, 0,           8'h00);
    plan_event(ACT_START,     1'b1, 0,           8'h00);
    plan_event(ACT_HANDS_ON,  1'b1, 1,           8'h00);         // ignored while running
    plan_event(ACT_TICK,      1'b0, 1,           8'h00);
    plan_event(ACT_RESET,     1'b1, 0,           8'h00);         // reset while running
    plan_config(DELAY_MAX);
    plan_event(ACT_HANDS_ON,  1'b1, SHORT_WORDS, CODE_HANDS_ON);
    plan_event(ACT_READY,     1'b1, 1,           8'h00);
    plan_event(ACT_UNUSED,    1'b0, 1,           8'h00);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_ready_delay(plan[i].cfg_val);
      end else begin
        send_event(plan[i].act, plan[i].lnk);
        if (plan[i].want_words != 0 &&
            (predicted_words != plan[i].want_words ||
             (predicted_words > 1 && predicted_code != plan[i].want_code)))
          flag_mismatch($sformatf("directed row %0d predicts %0d words code %h",
                                  i, predicted_words, predicted_code));
      end
    end

    // Sender gaps, heavy receiver stalls.
    random_phase(40, 16'($urandom_range(12, 1)));
    random_phase(40, DELAY_MAX);

    // Swap the idle rates.
    send_idle_pct = 64;
    recv_idle_pct = 29;
    random_phase(40, 16'h0000);
    random_phase(40, 16'($urandom_range(40, 13)));

    // Full rate both ways; one more stop / start / stop / reset run in between.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(40, 16'($urandom_range(12, 1)));
    send_event(ACT_STOP, 1'b1);
    send_event(ACT_START, 1'b1);
    run_ticks($urandom_range(30, 10));
    send_event(ACT_STOP, 1'b1);
    send_event(ACT_RESET, 1'b1);
    random_phase(40, 16'($urandom_range(60, 41)));

    // Drain, then give stray words time to show up.
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
